FILE: design/tkst_pkg.sv
// Shared widths, command codes and record types for the tick-keyed slot table.
package tkst_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = 7;
   localparam int CMD_W     = 2;
   localparam int TICK_W    = 32;
   localparam int HANDLE_W  = 32;
   localparam int SIZE_W    = 24;

   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [TICK_W-1:0]   tick;
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } slot_type;

   typedef struct packed {
      logic             start;
      logic             en;
      logic             active;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0]    n;
      logic                match;
      logic [IDX_W-1:0]    match_idx;
      logic [HANDLE_W-1:0] match_handle;
      logic [SIZE_W-1:0]   match_size;
      logic                free_hi;
      logic [IDX_W-1:0]    free_hi_idx;
      logic                free_any;
      logic [IDX_W-1:0]    free_any_idx;
      logic [IDX_W-1:0]    vic_idx;
      logic [HANDLE_W-1:0] vic_handle;
      logic [TICK_W-1:0]   min1;
      logic [TICK_W-1:0]   min2;
      logic [TICK_W-1:0]   max;
   } scan_res_type;

endpackage

FILE: design/tkst_cell.sv
// One slot of the table: a stage of the rotating ring with a direct write port.
module tkst_cell
   import tkst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  slot_type shift_in,
   input  logic     wr_en,
   input  slot_type wr_data,
   input  logic     clear_all,
   output slot_type slot_out
);

   logic                valid_ff;
   logic [TICK_W-1:0]   tick_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SIZE_W-1:0]   size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (clear_all) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= shift_in.valid;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (shift_en) begin
         tick_ff   <= shift_in.tick;
         handle_ff <= shift_in.handle;
         size_ff   <= shift_in.size;
      end else if (wr_en) begin
         tick_ff   <= wr_data.tick;
         handle_ff <= wr_data.handle;
         size_ff   <= wr_data.size;
      end
   end

   assign slot_out = '{valid: valid_ff, tick: tick_ff, handle: handle_ff, size: size_ff};

endmodule

FILE: design/tkst_scan.sv
// Scan accumulator at the head of the ring: match, free slots, victim, min/max.
module tkst_scan
   import tkst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  slot_type          cur,
   input  logic [TICK_W-1:0] key,
   input  logic [IDX_W-1:0]  head,
   output scan_res_type      res
);

   scan_res_type acc_ff, acc_in;
   logic         take;
   logic         free;
   logic         empty;
   logic         lo;

   always_comb begin
      acc_in = acc_ff;
      take   = ctl.en && ctl.active && cur.valid;
      free   = ctl.en && ctl.active && !cur.valid;
      empty  = (acc_ff.n == '0);
      lo     = empty || (cur.tick <= acc_ff.min1);
      if (ctl.start) begin
         acc_in.n        = '0;
         acc_in.match    = 1'b0;
         acc_in.free_hi  = 1'b0;
         acc_in.free_any = 1'b0;
      end else begin
         if (take) begin
            acc_in.n = acc_ff.n + 1'b1;
            if (!acc_ff.match && cur.tick == key) begin
               acc_in.match        = 1'b1;
               acc_in.match_idx    = ctl.idx;
               acc_in.match_handle = cur.handle;
               acc_in.match_size   = cur.size;
            end
            // <= keeps the highest index on equal ticks
            if (lo) begin
               acc_in.min1       = cur.tick;
               acc_in.vic_idx    = ctl.idx;
               acc_in.vic_handle = cur.handle;
               if (!empty) begin
                  acc_in.min2 = acc_ff.min1;
               end
            end else if (acc_ff.n == CNT_W'(1) || cur.tick < acc_ff.min2) begin
               acc_in.min2 = cur.tick;
            end
            if (empty || cur.tick > acc_ff.max) begin
               acc_in.max = cur.tick;
            end
         end
         if (free) begin
            if (!acc_ff.free_any) begin
               acc_in.free_any     = 1'b1;
               acc_in.free_any_idx = ctl.idx;
            end
            if (!acc_ff.free_hi && ctl.idx >= head) begin
               acc_in.free_hi     = 1'b1;
               acc_in.free_hi_idx = ctl.idx;
            end
         end
      end
   end

   // data fields hold through reset; only the flags and count are cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.n        <= '0;
         acc_ff.match    <= 1'b0;
         acc_ff.free_hi  <= 1'b0;
         acc_ff.free_any <= 1'b0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign res = acc_ff;

endmodule

FILE: design/tick_keyed_slot_table_top.sv
// Top level of the tick-keyed slot table: command sequencer, slot ring and scan unit.
// A command passes from idle through the head wrap, a full ring turn of scan steps and a finish
// state that raises rsp_valid; the wrap subtracts the depth once per step while a stale head is out of range.
// No new command is taken until the block is back in idle after the ring turn; busy is high until then.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active high) clears all valid bits, count, head; depth returns to 64.
module tick_keyed_slot_table_top
   import tkst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [TICK_W-1:0]   req_tick,
   input  logic [HANDLE_W-1:0] req_payload_handle,
   input  logic [SIZE_W-1:0]   req_payload_size,
   // result channel
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic                rsp_hit_existing,
   output logic                rsp_released,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic [SIZE_W-1:0]   rsp_out_size,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [TICK_W-1:0]   rsp_oldest_tick,
   output logic [TICK_W-1:0]   rsp_newest_tick,
   // configuration: active_slots
   input  logic                csr_we,
   input  logic [CNT_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRAP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    active_slots_ff;
   logic [CNT_W-1:0]    depth_ff;
   logic [CNT_W-1:0]    depth_in;
   logic [IDX_W-1:0]    head_ff;         // search head reduced modulo depth
   logic [IDX_W-1:0]    step_ff;         // slot index now sitting at the ring head
   logic [CNT_W-1:0]    head_diff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [TICK_W-1:0]   tick_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [CNT_W-1:0]    valid_count_ff;
   logic [IDX_W-1:0]    search_head_ff;

   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic                rsp_hit_ff;
   logic                rsp_rel_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [TICK_W-1:0]   rsp_oldest_ff;
   logic [TICK_W-1:0]   rsp_newest_ff;

   // finish-cycle decision
   logic                f_ok;
   logic                f_hit;
   logic                f_rel;
   logic [HANDLE_W-1:0] f_handle;
   logic [SIZE_W-1:0]   f_size;
   logic [CNT_W-1:0]    f_count;
   logic [IDX_W-1:0]    f_head;
   logic [TICK_W-1:0]   f_oldest;
   logic [TICK_W-1:0]   f_newest;
   logic                f_wr;
   logic [IDX_W-1:0]    f_wr_idx;
   logic                f_clear;
   logic [IDX_W-1:0]    free_idx;

   scan_ctl_type        scan_ctl;
   scan_res_type        scan_res;
   slot_type            ring [MAX_SLOTS];
   slot_type            wr_data;
   logic                shift_en;
   logic                wr_fire;
   logic                clear_fire;

   // Live depth: 0 acts as 1, above the built size acts as the built size.
   always_comb begin
      if (active_slots_ff == '0) begin
         depth_in = CNT_W'(1);
      end else if (active_slots_ff > CNT_W'(MAX_SLOTS)) begin
         depth_in = CNT_W'(MAX_SLOTS);
      end else begin
         depth_in = active_slots_ff;
      end
   end

   assign head_diff = {{(CNT_W-IDX_W){1'b0}}, head_ff} - depth_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= CNT_W'(MAX_SLOTS);
      end else if (csr_we) begin
         active_slots_ff <= csr_wdata;
      end
   end

   // (index + 1) modulo depth; index is always below depth here
   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] depth);
      logic [CNT_W-1:0] nxt;
      nxt = {{(CNT_W-IDX_W){1'b0}}, idx} + 1'b1;
      if (nxt == depth) begin
         return '0;
      end
      return nxt[IDX_W-1:0];
   endfunction

   // Decision taken once the ring has come back around.
   always_comb begin
      f_ok     = 1'b0;
      f_hit    = 1'b0;
      f_rel    = 1'b0;
      f_handle = '0;
      f_size   = '0;
      f_count  = valid_count_ff;
      f_head   = search_head_ff;
      f_wr     = 1'b0;
      f_wr_idx = scan_res.match_idx;
      f_clear  = 1'b0;
      free_idx = scan_res.free_hi ? scan_res.free_hi_idx : scan_res.free_any_idx;
      if (scan_res.n == '0) begin
         f_oldest = '0;
         f_newest = '0;
      end else begin
         f_oldest = scan_res.min1;
         f_newest = scan_res.max;
      end
      case (cmd_ff)
         CMD_STORE: begin
            if (size_ff != '0) begin
               if (scan_res.match) begin
                  // same tick stays, so oldest and newest do not move
                  f_ok     = 1'b1;
                  f_hit    = 1'b1;
                  f_rel    = 1'b1;
                  f_handle = scan_res.match_handle;
                  f_wr     = 1'b1;
               end else if (valid_count_ff < depth_ff && scan_res.free_any) begin
                  f_ok     = 1'b1;
                  f_wr     = 1'b1;
                  f_wr_idx = free_idx;
                  f_count  = valid_count_ff + 1'b1;
                  f_head   = wrap_next(free_idx, depth_ff);
                  if (scan_res.n == '0) begin
                     f_oldest = tick_ff;
                     f_newest = tick_ff;
                  end else begin
                     f_oldest = (tick_ff < scan_res.min1) ? tick_ff : scan_res.min1;
                     f_newest = (tick_ff > scan_res.max) ? tick_ff : scan_res.max;
                  end
               end else if (scan_res.n != '0) begin
                  // evict the lowest tick; the rest keep min2 and max
                  f_ok     = 1'b1;
                  f_rel    = 1'b1;
                  f_handle = scan_res.vic_handle;
                  f_wr     = 1'b1;
                  f_wr_idx = scan_res.vic_idx;
                  f_head   = wrap_next(scan_res.vic_idx, depth_ff);
                  if (scan_res.n >= CNT_W'(2)) begin
                     f_oldest = (tick_ff < scan_res.min2) ? tick_ff : scan_res.min2;
                     f_newest = (tick_ff > scan_res.max) ? tick_ff : scan_res.max;
                  end else begin
                     f_oldest = tick_ff;
                     f_newest = tick_ff;
                  end
               end
            end
         end
         CMD_LOOKUP: begin
            if (scan_res.match) begin
               f_ok     = 1'b1;
               f_hit    = 1'b1;
               f_handle = scan_res.match_handle;
               f_size   = scan_res.match_size;
            end
         end
         CMD_CLEAR: begin
            f_ok     = 1'b1;
            f_clear  = 1'b1;
            f_count  = '0;
            f_head   = '0;
            f_oldest = '0;
            f_newest = '0;
         end
         default: begin
            f_ok = 1'b0;
         end
      endcase
   end

   // Sequencer: state, counters, stored table state and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_count_ff <= '0;
         search_head_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff    <= req_command;
                  tick_ff   <= req_tick;
                  handle_ff <= req_payload_handle;
                  size_ff   <= req_payload_size;
                  depth_ff  <= depth_in;
                  head_ff   <= search_head_ff;
                  step_ff   <= '0;
                  state_ff  <= ST_WRAP;
               end
            end
            ST_WRAP: begin
               // stale head after a depth change: subtract until in range
               if ({{(CNT_W-IDX_W){1'b0}}, head_ff} >= depth_ff) begin
                  head_ff <= head_diff[IDX_W-1:0];
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == IDX_W'(MAX_SLOTS - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               valid_count_ff <= f_count;
               search_head_ff <= f_head;
               rsp_valid_ff   <= 1'b1;
               rsp_ok_ff      <= f_ok;
               rsp_hit_ff     <= f_hit;
               rsp_rel_ff     <= f_rel;
               rsp_handle_ff  <= f_handle;
               rsp_size_ff    <= f_size;
               rsp_count_ff   <= f_count;
               rsp_oldest_ff  <= f_oldest;
               rsp_newest_ff  <= f_newest;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign shift_en   = (state_ff == ST_SCAN);
   assign wr_fire    = (state_ff == ST_FINISH) && f_wr;
   assign clear_fire = (state_ff == ST_FINISH) && f_clear;
   assign wr_data    = '{valid: 1'b1, tick: tick_ff, handle: handle_ff, size: size_ff};

   assign scan_ctl.start  = (state_ff == ST_WRAP) &&
                            ({{(CNT_W-IDX_W){1'b0}}, head_ff} < depth_ff);
   assign scan_ctl.en     = shift_en;
   assign scan_ctl.active = ({{(CNT_W-IDX_W){1'b0}}, step_ff} < depth_ff);
   assign scan_ctl.idx    = step_ff;

   // Slot ring: each cell takes its upper neighbor's slot, so slot k
   // reaches cell 0 on scan step k and is home again after a full turn.
   for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
      localparam int NEXT = (k + 1) % MAX_SLOTS;
      tkst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .shift_in  (ring[NEXT]),
         .wr_en     (wr_fire && (f_wr_idx == IDX_W'(k))),
         .wr_data   (wr_data),
         .clear_all (clear_fire),
         .slot_out  (ring[k])
      );
   end

   tkst_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .cur   (ring[0]),
      .key   (tick_ff),
      .head  (head_ff),
      .res   (scan_res)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_hit_existing = rsp_hit_ff;
   assign rsp_released     = rsp_rel_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_out_size     = rsp_size_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_oldest_tick  = rsp_oldest_ff;
   assign rsp_newest_tick  = rsp_newest_ff;

endmodule

FILE: tb/tkst_checker.sv
// Result checker for the tick-keyed slot table: tracks the slots and compares every result.
module tkst_checker
   import tkst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [TICK_W-1:0]   req_tick,
   input  logic [HANDLE_W-1:0] req_payload_handle,
   input  logic [SIZE_W-1:0]   req_payload_size,
   input  logic                rsp_valid,
   input  logic                rsp_ok,
   input  logic                rsp_hit_existing,
   input  logic                rsp_released,
   input  logic [HANDLE_W-1:0] rsp_out_handle,
   input  logic [SIZE_W-1:0]   rsp_out_size,
   input  logic [CNT_W-1:0]    rsp_entry_count,
   input  logic [TICK_W-1:0]   rsp_oldest_tick,
   input  logic [TICK_W-1:0]   rsp_newest_tick,
   input  logic                csr_we,
   input  logic [CNT_W-1:0]    csr_wdata,
   output int                  error_count,
   output int                  pending_count,
   output int                  result_count
);

   typedef struct packed {
      logic                ok;
      logic                hit_existing;
      logic                released;
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
      logic [CNT_W-1:0]    count;
      logic [TICK_W-1:0]   oldest;
      logic [TICK_W-1:0]   newest;
   } reply_type;

   logic                slot_used   [MAX_SLOTS];
   logic [TICK_W-1:0]   slot_key    [MAX_SLOTS];
   logic [HANDLE_W-1:0] slot_buf    [MAX_SLOTS];
   logic [SIZE_W-1:0]   slot_bytes  [MAX_SLOTS];
   int unsigned         used_count;
   int unsigned         fill_head;
   logic [CNT_W-1:0]    depth_cfg;
   reply_type           expected_replies[$];

   // out-of-range depth settings clamp to 1..MAX_SLOTS
   function automatic int unsigned live_slots();
      if (depth_cfg == 0) return 1;
      if (depth_cfg > MAX_SLOTS) return MAX_SLOTS;
      return depth_cfg;
   endfunction

   function automatic int find_key(input int unsigned d, input logic [TICK_W-1:0] key);
      for (int i = 0; i < d; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void fill_slot(input int unsigned n, input logic [TICK_W-1:0] key,
                                     input logic [HANDLE_W-1:0] hd,
                                     input logic [SIZE_W-1:0] sz);
      slot_used[n]  = 1'b1;
      slot_key[n]   = key;
      slot_buf[n]   = hd;
      slot_bytes[n] = sz;
   endfunction

   function automatic reply_type run_command(input logic [CMD_W-1:0] cmd,
                                             input logic [TICK_W-1:0] key,
                                             input logic [HANDLE_W-1:0] hd,
                                             input logic [SIZE_W-1:0] sz);
      reply_type       r;
      int unsigned     d;
      int unsigned     j;
      int              hit_at;
      int              victim;
      logic [TICK_W-1:0] low;
      logic            any;
      r = '0;
      d = live_slots();
      case (cmd)
         CMD_STORE: begin
            if (sz != 0) begin
               hit_at = find_key(d, key);
               if (hit_at >= 0) begin
                  r.released     = 1'b1;
                  r.handle       = slot_buf[hit_at];
                  fill_slot(hit_at, key, hd, sz);
                  r.ok           = 1'b1;
                  r.hit_existing = 1'b1;
               end else begin
                  if (used_count < d) begin
                     for (int i = 0; i < d; i++) begin
                        j = (fill_head + i) % d;
                        if (!slot_used[j]) begin
                           fill_slot(j, key, hd, sz);
                           used_count++;
                           fill_head = (j + 1) % d;
                           r.ok = 1'b1;
                           break;
                        end
                     end
                  end
                  if (!r.ok) begin
                     // lowest tick goes; a later index wins a tie
                     victim = -1;
                     low    = '1;
                     for (int i = 0; i < d; i++) begin
                        if (slot_used[i] && slot_key[i] <= low) begin
                           low    = slot_key[i];
                           victim = i;
                        end
                     end
                     if (victim >= 0) begin
                        r.released = 1'b1;
                        r.handle   = slot_buf[victim];
                        fill_slot(victim, key, hd, sz);
                        fill_head  = (victim + 1) % d;
                        r.ok       = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_LOOKUP: begin
            hit_at = find_key(d, key);
            if (hit_at >= 0) begin
               r.ok           = 1'b1;
               r.hit_existing = 1'b1;
               r.handle       = slot_buf[hit_at];
               r.size         = slot_bytes[hit_at];
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < MAX_SLOTS; i++) slot_used[i] = 1'b0;
            used_count = 0;
            fill_head  = 0;
            r.ok       = 1'b1;
         end
         default: ;
      endcase
      any = 1'b0;
      for (int i = 0; i < d; i++) begin
         if (slot_used[i]) begin
            if (!any || slot_key[i] < r.oldest) r.oldest = slot_key[i];
            if (!any || slot_key[i] > r.newest) r.newest = slot_key[i];
            any = 1'b1;
         end
      end
      r.count = used_count[CNT_W-1:0];
      return r;
   endfunction

   function automatic string show(input reply_type r);
      return $sformatf("ok=%0b hit=%0b rel=%0b handle=%h size=%h count=%0d oldest=%h newest=%h",
                       r.ok, r.hit_existing, r.released, r.handle, r.size, r.count,
                       r.oldest, r.newest);
   endfunction

   always @(posedge clock) begin : watch
      reply_type want;
      reply_type got;
      string     diffs;
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) slot_used[i] = 1'b0;
         used_count = 0;
         fill_head  = 0;
         depth_cfg  = CNT_W'(MAX_SLOTS);
         expected_replies.delete();
         error_count  = 0;
         result_count = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_ok, rsp_hit_existing, rsp_released, rsp_out_handle, rsp_out_size,
                    rsp_entry_count, rsp_oldest_tick, rsp_newest_tick};
            result_count++;
            if (expected_replies.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result with no item waiting: %s", $time, show(got));
            end else begin
               want  = expected_replies.pop_front();
               diffs = "";
               if (got.ok !== want.ok)                     diffs = {diffs, " ok"};
               if (got.hit_existing !== want.hit_existing) diffs = {diffs, " hit_existing"};
               if (got.released !== want.released)         diffs = {diffs, " released"};
               if (got.handle !== want.handle)             diffs = {diffs, " out_handle"};
               if (got.size !== want.size)                 diffs = {diffs, " out_size"};
               if (got.count !== want.count)               diffs = {diffs, " entry_count"};
               if (got.oldest !== want.oldest)             diffs = {diffs, " oldest_tick"};
               if (got.newest !== want.newest)             diffs = {diffs, " newest_tick"};
               if (diffs != "") begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: result %0d wrong in%s", $time, result_count, diffs);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
               end
            end
         end
         if (csr_we) depth_cfg = csr_wdata;
         if (start && !busy)
            expected_replies.push_back(run_command(req_command, req_tick,
                                                   req_payload_handle, req_payload_size));
      end
      pending_count = expected_replies.size();
   end

endmodule

FILE: tb/tb_tick_keyed_slot_table_top.sv
// Testbench top for the tick-keyed slot table: stimulus, configuration and verdict.
module tb_tick_keyed_slot_table_top;
   import tkst_pkg::*;

   // Code 3 is not a command; the block must ignore it.
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   // Quiet time at the end: covers a full command plus the worst head wrap.
   localparam int SETTLE_CYCLES = 2 * MAX_SLOTS + 16;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 135;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                start              = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command        = CMD_STORE;
   logic [TICK_W-1:0]   req_tick           = '0;
   logic [HANDLE_W-1:0] req_payload_handle = '0;
   logic [SIZE_W-1:0]   req_payload_size   = '0;
   logic                rsp_valid;
   logic                rsp_ok;
   logic                rsp_hit_existing;
   logic                rsp_released;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic [SIZE_W-1:0]   rsp_out_size;
   logic [CNT_W-1:0]    rsp_entry_count;
   logic [TICK_W-1:0]   rsp_oldest_tick;
   logic [TICK_W-1:0]   rsp_newest_tick;
   logic                csr_we             = 1'b0;
   logic [CNT_W-1:0]    csr_wdata          = '0;

   int mismatches;
   int waiting;
   int checked;

   // Stimulus bookkeeping.
   int sender_idle_pct = 22;
   int n_store         = 0;
   int n_lookup        = 0;
   int n_clear         = 0;
   int n_unknown       = 0;
   int depth_writes    = 0;

   // Ticks stored recently; lookups and replacing stores draw from here so that
   // they actually hit something.
   logic [TICK_W-1:0] recent_ticks[$];

   always #5 clock = ~clock;

   tick_keyed_slot_table_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_tick           (req_tick),
      .req_payload_handle (req_payload_handle),
      .req_payload_size   (req_payload_size),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_hit_existing   (rsp_hit_existing),
      .rsp_released       (rsp_released),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_size       (rsp_out_size),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_oldest_tick    (rsp_oldest_tick),
      .rsp_newest_tick    (rsp_newest_tick),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   tkst_checker slot_table_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_tick           (req_tick),
      .req_payload_handle (req_payload_handle),
      .req_payload_size   (req_payload_size),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_hit_existing   (rsp_hit_existing),
      .rsp_released       (rsp_released),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_size       (rsp_out_size),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_oldest_tick    (rsp_oldest_tick),
      .rsp_newest_tick    (rsp_newest_tick),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .error_count        (mismatches),
      .pending_count      (waiting),
      .result_count       (checked)
   );

   // Hard stop. The slowest legal run is roughly 1700 items, each with a full scan,
   // a head wrap and long sender gaps, near 3.5M time units.
   initial begin
      #20_000_000;
      $display("tb_tick_keyed_slot_table_top: done, errors");
      $finish;
   end

   // Present one item and hold it until the block takes it.
   // Called and returns in the time step of a rising edge; busy is sampled on
   // the falling edge, where it is stable up to the next rising edge.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TICK_W-1:0] tk,
                            input logic [HANDLE_W-1:0] hd, input logic [SIZE_W-1:0] sz);
      logic taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_command        <= cmd;
      req_tick           <= tk;
      req_payload_handle <= hd;
      req_payload_size   <= sz;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      case (cmd)
         CMD_STORE:  n_store++;
         CMD_LOOKUP: n_lookup++;
         CMD_CLEAR:  n_clear++;
         default:    n_unknown++;
      endcase
      if (cmd == CMD_STORE && sz != 0) begin
         recent_ticks.push_back(tk);
         if (recent_ticks.size() > MAX_SLOTS) void'(recent_ticks.pop_front());
      end
   endtask

   // Stop sending and wait until every item has its result and the block is idle.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (waiting != 0 || busy);
      @(posedge clock);
   endtask

   // The depth register is only touched while the block is idle.
   task automatic write_depth(input logic [CNT_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      depth_writes++;
   endtask

   // Fresh ticks: a cluster near zero, a cluster near all-ones, and full range.
   function automatic logic [TICK_W-1:0] fresh_tick();
      int r;
      r = $urandom_range(99);
      if (r < 30) return TICK_W'($urandom_range(31));
      if (r < 40) return TICK_W'(32'hFFFF_FFE0 + $urandom_range(31));
      return $urandom();
   endfunction

   function automatic logic [TICK_W-1:0] known_tick();
      if (recent_ticks.size() == 0) return fresh_tick();
      return recent_ticks[$urandom_range(recent_ticks.size() - 1)];
   endfunction

   task automatic random_item(input int clear_pct);
      int                  pick;
      int                  r;
      logic [CMD_W-1:0]    cmd;
      logic [TICK_W-1:0]   tk;
      logic [HANDLE_W-1:0] hd;
      logic [SIZE_W-1:0]   sz;
      pick = $urandom_range(99);
      r    = $urandom_range(99);
      hd   = (r < 5) ? '0 : (r < 10) ? '1 : $urandom();
      r    = $urandom_range(99);
      if (r < 8)       sz = '0;                           // refused store
      else if (r < 13) sz = '1;
      else if (r < 30) sz = SIZE_W'($urandom_range(255, 1));
      else             sz = SIZE_W'($urandom_range(24'hFF_FFFF, 1));
      if (pick < clear_pct) begin
         cmd = CMD_CLEAR;
         tk  = $urandom();
      end else if (pick < clear_pct + 3) begin
         cmd = CMD_UNKNOWN;
         tk  = $urandom();
      end else if (pick < 60) begin
         cmd = CMD_STORE;
         tk  = ($urandom_range(99) < 40) ? known_tick() : fresh_tick();
      end else begin
         cmd = CMD_LOOKUP;
         tk  = ($urandom_range(99) < 70) ? known_tick() : fresh_tick();
      end
      send_item(cmd, tk, hd, sz);
   endtask

   // Depth for each random phase: extremes, out-of-range values and a few draws.
   function automatic logic [CNT_W-1:0] phase_depth(input int p);
      case (p)
         0:       return CNT_W'(64);
         1:       return CNT_W'(1);
         2:       return CNT_W'(127);  // above range, acts as the full table
         3:       return CNT_W'(3);
         4:       return CNT_W'(0);    // zero, acts as a single slot
         5:       return CNT_W'(8);
         7:       return CNT_W'(2);
         8:       return CNT_W'(64);
         10:      return CNT_W'(16);
         default: return CNT_W'($urandom_range(127));
      endcase
   endfunction

   initial begin
      int goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: field extremes, every command, refusals, ties ----
      send_item(CMD_LOOKUP, '0, '0, '0);                         // miss on empty table
      send_item(CMD_STORE, '0, '1, '1);                           // lowest tick, max fields
      send_item(CMD_STORE, '1, '0, SIZE_W'(1));                   // highest tick
      send_item(CMD_STORE, TICK_W'(7), HANDLE_W'(32'h55AA_55AA), '0); // zero size refused
      send_item(CMD_LOOKUP, '0, '0, '0);
      send_item(CMD_LOOKUP, '1, '0, '0);
      send_item(CMD_STORE, '0, HANDLE_W'(32'h1234_5678), SIZE_W'(24'h00_ABCD)); // replace
      send_item(CMD_UNKNOWN, '1, '1, '1);                         // ignored
      send_item(CMD_CLEAR, '0, '0, '0);

      // Stale slots: shrink the depth without a clear so a tick ends up twice,
      // then grow it back; eviction must pick the later of the two equal ticks.
      write_depth(CNT_W'(2));
      send_item(CMD_STORE, TICK_W'(5), HANDLE_W'(32'hA), SIZE_W'(1));
      send_item(CMD_STORE, TICK_W'(9), HANDLE_W'(32'hB), SIZE_W'(2));
      write_depth(CNT_W'(1));
      send_item(CMD_STORE, TICK_W'(9), HANDLE_W'(32'hC), SIZE_W'(3)); // evicts slot 0
      write_depth(CNT_W'(2));
      send_item(CMD_STORE, TICK_W'(1), HANDLE_W'(32'hD), SIZE_W'(4)); // tie on tick 9
      send_item(CMD_LOOKUP, TICK_W'(9), '0, '0);
      send_item(CMD_LOOKUP, TICK_W'(1), '0, '0);
      write_depth(CNT_W'(0));
      send_item(CMD_STORE, TICK_W'(3), HANDLE_W'(32'hE), SIZE_W'(5));
      write_depth(CNT_W'(127));
      send_item(CMD_STORE, TICK_W'(100), HANDLE_W'(32'hF), SIZE_W'(6)); // fills slot 2
      send_item(CMD_LOOKUP, TICK_W'(3), '0, '0);
      write_depth(CNT_W'(2));
      send_item(CMD_STORE, TICK_W'(200), HANDLE_W'(32'h10), SIZE_W'(7)); // stale head wraps
      send_item(CMD_CLEAR, '0, '0, '0);

      // ---- random phases ----
      // Sender idle rate: 22% for the first third, 85% for the second, none after.
      for (int p = 0; p < PHASES; p++) begin
         sender_idle_pct = (p < PHASES / 3) ? 22 : (p < 2 * PHASES / 3) ? 85 : 0;
         write_depth(phase_depth(p));
         // Most phases start clean, as software would; the rest keep stale slots.
         if (p % 3 != 2) send_item(CMD_CLEAR, '0, '0, '0);
         goal = n_store + n_lookup + n_clear + PHASE_ITEMS;
         // Some phases never clear so the big table fills up and starts evicting.
         while (n_store + n_lookup + n_clear < goal)
            random_item((p % 4 == 0) ? 0 : 2);
      end

      // Everything sent: wait for the last results, then watch for strays.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("tb: %0d stores, %0d lookups, %0d clears, %0d unknown codes, %0d depth writes",
               n_store, n_lookup, n_clear, n_unknown, depth_writes);
      $display("tb: %0d results checked, %0d failures", checked, mismatches);
      if (mismatches == 0 && waiting == 0)
         $display("tb_tick_keyed_slot_table_top: done, clean");
      else
         $display("tb_tick_keyed_slot_table_top: done, errors");
      $finish;
   end

endmodule

FILE: tick_keyed_slot_table_top.f
design/tkst_pkg.sv
design/tkst_cell.sv
design/tkst_scan.sv
design/tick_keyed_slot_table_top.sv
tb/tkst_checker.sv
tb/tb_tick_keyed_slot_table_top.sv
